// ===== rtl/b64u_pkg.sv =====
// b64u_pkg: shared types, register indexes and alphabet functions for the
// unpadded base64 codec. No dependencies.
package b64u_pkg;

  localparam int SYM_W    = 8;
  localparam int SEXTET_W = 6;
  localparam int CFG_IDX_W = 1;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_DIRECTION = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ALPHABET  = 1'd1;

  typedef enum logic {
    DIR_ENCODE = 1'b0,
    DIR_DECODE = 1'b1
  } dir_t;

  typedef enum logic {
    ALPHA_DIGITS_FIRST = 1'b0,
    ALPHA_STANDARD     = 1'b1
  } alpha_t;

  typedef struct packed {
    logic                ok;
    logic [SEXTET_W-1:0] idx;
  } dec_t;

  // One queued result word: symbol plus run-end flag.
  typedef struct packed {
    logic [SYM_W-1:0] sym;
    logic             last;
  } res_t;

  // Sextet -> alphabet character
  function automatic logic [SYM_W-1:0] enc_char(input logic [SEXTET_W-1:0] idx,
                                                input alpha_t alpha);
    logic [SYM_W-1:0] i8;
    logic [SYM_W-1:0] c;
    i8 = {2'b00, idx};
    if (idx == 6'd62) begin
      c = 8'h2B;                                 // '+'
    end else if (idx == 6'd63) begin
      c = 8'h2F;                                 // '/'
    end else if (alpha == ALPHA_DIGITS_FIRST) begin
      if (idx < 6'd10)      c = i8 + 8'd48;
      else if (idx < 6'd36) c = i8 + 8'd55;
      else                  c = i8 + 8'd61;
    end else begin
      if (idx < 6'd26)      c = i8 + 8'd65;
      else if (idx < 6'd52) c = i8 + 8'd71;
      else                  c = i8 - 8'd4;
    end
    return c;
  endfunction

  // Alphabet character -> sextet, ok low when the character is not in the set
  function automatic dec_t dec_index(input logic [SYM_W-1:0] c, input alpha_t alpha);
    dec_t             r;
    logic [SYM_W-1:0] d;
    r.ok = 1'b1;
    d    = 8'd0;
    if (c == 8'h2B) begin
      d = 8'd62;
    end else if (c == 8'h2F) begin
      d = 8'd63;
    end else if (c >= 8'h30 && c <= 8'h39) begin
      d = (alpha == ALPHA_DIGITS_FIRST) ? c - 8'd48 : c + 8'd4;
    end else if (c >= 8'h41 && c <= 8'h5A) begin
      d = (alpha == ALPHA_DIGITS_FIRST) ? c - 8'd55 : c - 8'd65;
    end else if (c >= 8'h61 && c <= 8'h7A) begin
      d = (alpha == ALPHA_DIGITS_FIRST) ? c - 8'd61 : c - 8'd71;
    end else begin
      r.ok = 1'b0;
    end
    r.idx = d[SEXTET_W-1:0];
    return r;
  endfunction

endpackage

// ===== rtl/base64_unpadded_codec.sv =====
// base64_unpadded_codec: streaming base64 encoder/decoder without padding.
// Depends on b64u_pkg.
//
// Encode (direction 0) takes bytes and emits 1 or 2 alphabet characters per
// byte; the byte marked tlast also flushes any remaining bits as a final
// zero-filled character. Decode (direction 1) takes characters and emits 0 or
// 1 byte; an invalid character halts decoding until the tlast word, and
// leftover bits at tlast are dropped. All stream state clears after the tlast
// word and on a write that changes direction. Each accepted word is processed
// in the cycle it is accepted; its results are registered into a 4-word
// output queue that drives out_*. The output port moves one word per cycle
// while out_tready is high, so throughput is set by result count: decode
// then sustains one character per cycle, encode less, as a byte can yield two.
// in_tready is high while the queue has room for two words, so input keeps
// flowing while results wait on the output side.
module base64_unpadded_codec
  import b64u_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  // config write port
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_idx,
  input  logic                 cfg_wdata,
  // input stream
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [SYM_W-1:0]     in_tdata,   // [7:0] symbol_in
  input  logic                 in_tlast,   // stream_last
  // result stream
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [SYM_W-1:0]     out_tdata,  // [7:0] symbol_out
  output logic                 out_tlast   // run_end
);

  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // Config and stream state
  dir_t                direction_r,  direction_nxt;
  alpha_t              alphabet_r,   alphabet_nxt;
  logic [5:0]          bit_buffer_r, bit_buffer_nxt;
  logic [2:0]          bit_count_r,  bit_count_nxt;
  logic                halted_r,     halted_nxt;

  // Output queue
  res_t                q_mem_r [QDEPTH];
  logic [QPTR_W-1:0]   q_wp_r, q_wp_nxt;
  logic [QPTR_W-1:0]   q_rp_r, q_rp_nxt;
  logic [QCNT_W-1:0]   q_cnt_r, q_cnt_nxt;

  logic                in_acc;
  logic                out_acc;

  // Per-word datapath
  logic [2:0]          cnt_c;
  logic [6:0]          cnt_mask;
  logic [5:0]          buf_m;
  // encode
  logic [13:0]         acc_e, acc_e1, acc_e2;
  logic [3:0]          a_e, a_e1, a_e2;
  logic [13:0]         sh_e0, sh_e1, sh_fl;
  // decode
  dec_t                dec;
  logic [11:0]         acc_d, acc_d1, sh_d;
  logic [3:0]          a_d, a_d1;
  // results of this word
  logic [1:0]          res_n;
  res_t                res0, res1;
  logic [5:0]          st_buf;
  logic [2:0]          st_cnt;
  logic                st_halt;

  assign in_acc  = in_tvalid && in_tready;
  assign out_acc = out_tvalid && out_tready;

  // Room for two results is needed before a word is taken.
  assign in_tready  = (q_cnt_r <= QCNT_W'(QDEPTH - 2));
  assign out_tvalid = (q_cnt_r != '0);
  assign out_tdata  = q_mem_r[q_rp_r].sym;
  assign out_tlast  = q_mem_r[q_rp_r].last;

  // Pending bits above bit_count are ignored; count saturates at 6.
  assign cnt_c    = (bit_count_r > 3'd6) ? 3'd6 : bit_count_r;
  assign cnt_mask = (7'd1 << cnt_c) - 7'd1;
  assign buf_m    = bit_buffer_r & cnt_mask[5:0];

  always_comb begin
    // encode path: up to two sextets plus the tlast flush
    acc_e  = {buf_m, in_tdata};
    a_e    = {1'b0, cnt_c} + 4'd8;
    a_e1   = a_e - 4'd6;
    sh_e0  = acc_e >> a_e1;
    acc_e1 = acc_e & ((14'd1 << a_e1) - 14'd1);
    a_e2   = a_e1 - 4'd6;
    sh_e1  = acc_e1 >> a_e2;
    acc_e2 = acc_e1 & ((14'd1 << a_e2) - 14'd1);
    sh_fl  = acc_e1 << (4'd6 - a_e1);

    // decode path
    dec    = dec_index(in_tdata, alphabet_r);
    acc_d  = {buf_m, dec.idx};
    a_d    = {1'b0, cnt_c} + 4'd6;
    a_d1   = a_d - 4'd8;
    sh_d   = acc_d >> a_d1;
    acc_d1 = acc_d & ((12'd1 << a_d1) - 12'd1);

    res_n   = 2'd0;
    res0    = '0;
    res1    = '0;
    st_buf  = bit_buffer_r;
    st_cnt  = bit_count_r;
    st_halt = halted_r;

    if (direction_r == DIR_ENCODE) begin
      res0.sym = enc_char(sh_e0[5:0], alphabet_r);
      if (a_e1 >= 4'd6) begin
        res_n     = 2'd2;
        res1.sym  = enc_char(sh_e1[5:0], alphabet_r);
        res1.last = 1'b1;
        st_buf    = acc_e2[5:0];
        st_cnt    = a_e2[2:0];
      end else begin
        st_buf = acc_e1[5:0];
        st_cnt = a_e1[2:0];
        if (in_tlast && a_e1 != 4'd0) begin
          res_n     = 2'd2;
          res1.sym  = enc_char(sh_fl[5:0], alphabet_r);
          res1.last = 1'b1;
        end else begin
          res_n     = 2'd1;
          res0.last = 1'b1;
        end
      end
    end else if (!halted_r) begin
      if (!dec.ok) begin
        st_halt = 1'b1;        // invalid character: stop until tlast
      end else if (a_d >= 4'd8) begin
        res_n     = 2'd1;
        res0.sym  = sh_d[7:0];
        res0.last = 1'b1;
        st_buf    = acc_d1[5:0];
        st_cnt    = a_d1[2:0];
      end else begin
        st_buf = acc_d[5:0];
        st_cnt = a_d[2:0];
      end
    end

    // end of string clears the bit buffer and count, halted included
    if (in_tlast) begin
      st_buf  = '0;
      st_cnt  = '0;
      st_halt = 1'b0;
    end
  end

  // Next-state: stream state and config
  always_comb begin
    direction_nxt  = direction_r;
    alphabet_nxt   = alphabet_r;
    bit_buffer_nxt = bit_buffer_r;
    bit_count_nxt  = bit_count_r;
    halted_nxt     = halted_r;

    if (in_acc) begin
      bit_buffer_nxt = st_buf;
      bit_count_nxt  = st_cnt;
      halted_nxt     = st_halt;
    end

    if (cfg_we) begin
      unique case (cfg_idx)
        REG_DIRECTION: begin
          direction_nxt = dir_t'(cfg_wdata);
          if (dir_t'(cfg_wdata) != direction_r) begin
            bit_buffer_nxt = '0;
            bit_count_nxt  = '0;
            halted_nxt     = 1'b0;
          end
        end
        REG_ALPHABET: alphabet_nxt = alpha_t'(cfg_wdata);
        default: ;
      endcase
    end
  end

  // Next-state: queue pointers
  always_comb begin
    logic [1:0] push_n;
    push_n    = in_acc ? res_n : 2'd0;
    q_wp_nxt  = q_wp_r + QPTR_W'(push_n);
    q_rp_nxt  = q_rp_r + QPTR_W'(out_acc);
    q_cnt_nxt = q_cnt_r + QCNT_W'(push_n) - QCNT_W'(out_acc);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      direction_r  <= DIR_ENCODE;
      alphabet_r   <= ALPHA_DIGITS_FIRST;
      bit_buffer_r <= '0;
      bit_count_r  <= '0;
      halted_r     <= 1'b0;
      q_wp_r       <= '0;
      q_rp_r       <= '0;
      q_cnt_r      <= '0;
    end else begin
      direction_r  <= direction_nxt;
      alphabet_r   <= alphabet_nxt;
      bit_buffer_r <= bit_buffer_nxt;
      bit_count_r  <= bit_count_nxt;
      halted_r     <= halted_nxt;
      q_wp_r       <= q_wp_nxt;
      q_rp_r       <= q_rp_nxt;
      q_cnt_r      <= q_cnt_nxt;
    end
  end

  // Queue storage, payload only
  always_ff @(posedge clk) begin
    if (in_acc && res_n != 2'd0) begin
      q_mem_r[q_wp_r] <= res0;
    end
    if (in_acc && res_n == 2'd2) begin
      q_mem_r[q_wp_r + QPTR_W'(1)] <= res1;
    end
  end

endmodule

// ===== rtl/b64u_checker.sv =====
// b64u_checker: port-level assertions for base64_unpadded_codec, bound to
// the top level. Depends on b64u_pkg for port widths.
module b64u_checker
  import b64u_pkg::*;
(
  input logic                 clk,
  input logic                 rst_n,
  input logic                 cfg_we,
  input logic [CFG_IDX_W-1:0] cfg_idx,
  input logic                 cfg_wdata,
  input logic                 in_tvalid,
  input logic                 in_tready,
  input logic [SYM_W-1:0]     in_tdata,
  input logic                 in_tlast,
  input logic                 out_tvalid,
  input logic                 out_tready,
  input logic [SYM_W-1:0]     out_tdata,
  input logic                 out_tlast
);

  // stalled result word stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("out_tvalid dropped while stalled");

  // stalled result word keeps its payload
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata) && $stable(out_tlast))
    else $error("result word changed while stalled");

  // no result appears without an accepted input word before it
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid && !(in_tvalid && in_tready) |=> !out_tvalid)
    else $error("result word without input");

  // queue empty right after reset
  a_reset_empty: assert property (@(posedge clk)
    rst_n && $past(!rst_n) |-> !out_tvalid)
    else $error("result word offered after reset");

  // with the queue empty there is room for input
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled with empty queue");

endmodule

bind base64_unpadded_codec b64u_checker u_b64u_checker (.*);
